/* design/bspe_pkg.sv */
package bspe_pkg;

  localparam int MAX_POINTS = 64;
  localparam int MAX_DEGREE = 7;
  localparam int FRAC_BITS  = 16;
  localparam int KNOT_DEPTH = MAX_POINTS + MAX_DEGREE + 1;
  localparam int KNOT_W     = FRAC_BITS + 1;
  localparam int COORD_W    = FRAC_BITS + 8;
  localparam int POINT_W    = 3 * COORD_W;
  localparam int KADDR_W    = $clog2(KNOT_DEPTH);
  localparam int PADDR_W    = $clog2(MAX_POINTS);
  localparam int WADDR_W    = $clog2(MAX_DEGREE + 1);
  localparam int IDX_W      = 7;
  localparam int DEG_W      = 3;
  localparam int CNT_W      = 7;

  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 80;

  typedef enum logic [1:0] {
    OP_KNOT  = 2'd0,
    OP_POINT = 2'd1,
    OP_EVAL  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_POINT = 2'd0,
    ST_WRITE = 2'd1,
    ST_OOD   = 2'd2
  } status_t;

  localparam logic REG_DEGREE      = 1'b0;
  localparam logic REG_POINT_COUNT = 1'b1;

endpackage

/* design/bspline_point_evaluator.sv */
// Channel   Dir  Handshake          Payload
// s_*       in   tvalid/tready      tuser: opcode; tdata: index, knot, x, y, z, t
// m_*       out  tvalid/tready      tuser: status; tdata: span, x, y, z
// cfg_*     in   cfg_we (no wait)   cfg_index selects degree or point_count
//
// A write answers through the S_DONE state and the output register. An
// evaluation of degree p first sweeps the knots and copies the points, then
// runs p*(p+1)/2 interpolation steps through the shared restoring divider
// (skipped when the weight is 0 or 1) and three passes of one multiplier
// pair, then finishes in S_FIN.
// Reset (rst, synchronous) clears the sequencer, the output word and the
// registers to degree 3 and 4 points; the stores are undefined until written.
// A new word is taken whenever the sequencer is idle, even while a result
// still waits on m_tready; a finished result holds until the output is free.
module bspline_point_evaluator
  import bspe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // entry_index[6:0], knot_value[23:7], point_x[47:24], point_y[71:48],
  // point_z[95:72], t_param[112:96], zero fill
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // opcode[1:0]
  input  logic [1:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // span_index[6:0], curve_x[30:7], curve_y[54:31], curve_z[78:55], zero fill
  output logic [OUT_DATA_W-1:0] m_tdata,
  // status[1:0]
  output logic [1:0]            m_tuser,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [6:0]            cfg_data
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_SEARCH = 11'b00000000010,
    S_COPY   = 11'b00000000100,
    S_RD     = 11'b00000001000,
    S_LD     = 11'b00000010000,
    S_DIV    = 11'b00000100000,
    S_MUL    = 11'b00001000000,
    S_ACC    = 11'b00010000000,
    S_WR     = 11'b00100000000,
    S_FIN    = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } state_t;

  state_t state;

  // Configuration
  logic [DEG_W-1:0] degree;
  logic [CNT_W-1:0] point_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      degree      <= DEG_W'(3);
      point_count <= CNT_W'(4);
    end else if (cfg_we) begin
      if (cfg_index == REG_DEGREE) begin
        degree <= (cfg_data[2:0] == 3'd0) ? DEG_W'(1) : cfg_data[2:0];
      end else begin
        if (cfg_data == 7'd0)
          point_count <= CNT_W'(1);
        else if (cfg_data > CNT_W'(MAX_POINTS))
          point_count <= CNT_W'(MAX_POINTS);
        else
          point_count <= cfg_data;
      end
    end
  end

  // Input word fields
  logic [1:0]         in_op;
  logic [IDX_W-1:0]   in_idx;
  logic [KNOT_W-1:0]  in_knot;
  logic [POINT_W-1:0] in_point;
  logic [KNOT_W-1:0]  in_t;

  assign in_op    = s_tuser;
  assign in_idx   = s_tdata[6:0];
  assign in_knot  = s_tdata[23:7];
  assign in_point = s_tdata[95:24];
  assign in_t     = s_tdata[112:96];

  logic accept;
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Memories
  logic [KNOT_W-1:0]  knot_mem [KNOT_DEPTH];
  logic [POINT_W-1:0] point_mem [MAX_POINTS];
  logic [POINT_W-1:0] work_mem [MAX_DEGREE+1];

  logic [KADDR_W-1:0] knot_addr_a, knot_addr_b;
  logic [KNOT_W-1:0]  knot_qa, knot_qb;
  logic [PADDR_W-1:0] point_addr;
  logic [POINT_W-1:0] point_q;
  logic [WADDR_W-1:0] work_addr_a, work_addr_b, work_waddr;
  logic [POINT_W-1:0] work_qa, work_qb, work_wdata;
  logic               work_we;

  always_ff @(posedge clk) begin
    if (accept && in_op == OP_KNOT && in_idx < IDX_W'(KNOT_DEPTH))
      knot_mem[in_idx[KADDR_W-1:0]] <= in_knot;
    knot_qa <= knot_mem[knot_addr_a];
    knot_qb <= knot_mem[knot_addr_b];
  end

  always_ff @(posedge clk) begin
    if (accept && in_op == OP_POINT && in_idx < IDX_W'(MAX_POINTS))
      point_mem[in_idx[PADDR_W-1:0]] <= in_point;
    point_q <= point_mem[point_addr];
  end

  always_ff @(posedge clk) begin
    if (work_we)
      work_mem[work_waddr] <= work_wdata;
    work_qa <= work_mem[work_addr_a];
    work_qb <= work_mem[work_addr_b];
  end

  // Evaluation context
  logic [KNOT_W-1:0]  t_reg;
  logic [CNT_W-1:0]   kcnt, kidx;
  logic               kv;
  logic [KNOT_W-1:0]  knot_p, prev;
  logic               found;
  logic [IDX_W-1:0]   span;
  logic [3:0]         ccnt;
  logic [WADDR_W-1:0] cidx;
  logic               cv;
  logic [WADDR_W-1:0] kk, jj;
  logic [KNOT_W-1:0]  rem, den;
  logic [FRAC_BITS-1:0] quo;
  logic [3:0]         dcnt;
  logic [KNOT_W-1:0]  alpha;
  logic [1:0]         coord;
  logic [8:0]         mag_hi_unused;
  logic [25:0]        ph;
  logic [32:0]        pl;
  logic               neg;
  logic signed [COORD_W-1:0] a_reg;
  logic [POINT_W-1:0] new_w;

  logic [1:0]         res_status;
  logic [IDX_W-1:0]   res_span;
  logic [POINT_W-1:0] res_point;

  // Address generation
  logic [IDX_W-1:0] base_i, hi_i;
  assign base_i = span - IDX_W'(degree) + IDX_W'(kk);
  assign hi_i   = base_i + IDX_W'(degree) + IDX_W'(1) - IDX_W'(jj);

  always_comb begin
    if (state == S_SEARCH)
      knot_addr_a = kcnt[KADDR_W-1:0];
    else
      knot_addr_a = base_i[KADDR_W-1:0];
    knot_addr_b = hi_i[KADDR_W-1:0];
    point_addr  = PADDR_W'(span - IDX_W'(degree) + IDX_W'(ccnt));
    work_addr_a = kk - WADDR_W'(1);
    work_addr_b = kk;
    work_we     = 1'b0;
    work_waddr  = kk;
    work_wdata  = new_w;
    if (state == S_COPY && cv) begin
      work_we    = 1'b1;
      work_waddr = cidx;
      work_wdata = point_q;
    end else if (state == S_WR) begin
      work_we = 1'b1;
    end
  end

  // Span test on the word just read
  logic hit, at_end;
  assign hit    = (prev <= t_reg) && (t_reg < knot_qa);
  assign at_end = kv && (kidx == point_count);

  // Weight setup
  logic [KNOT_W-1:0] w_num, w_den;
  assign w_num = t_reg - knot_qa;
  assign w_den = knot_qb - knot_qa;

  logic [KNOT_W:0] rem2;
  assign rem2 = {rem, 1'b0};

  // Lerp datapath
  logic signed [COORD_W-1:0] ca, cb;
  logic signed [COORD_W:0]   diff;
  logic [COORD_W:0]          mag;
  assign ca   = work_qa[coord*COORD_W +: COORD_W];
  assign cb   = work_qb[coord*COORD_W +: COORD_W];
  assign diff = {cb[COORD_W-1], cb} - {ca[COORD_W-1], ca};
  assign mag  = diff[COORD_W] ? (COORD_W+1)'(0) - diff : diff;
  assign mag_hi_unused = mag[COORD_W:FRAC_BITS];

  logic [33:0]       pl_rnd;
  logic [26:0]       qsum;
  logic signed [28:0] sum;
  logic signed [COORD_W-1:0] sat;
  assign pl_rnd = {1'b0, pl} + 34'(1 << (FRAC_BITS - 1));
  assign qsum   = 27'(ph) + 27'(pl_rnd[33:FRAC_BITS]);
  assign sum    = neg ? 29'(a_reg) - 29'(qsum) : 29'(a_reg) + 29'(qsum);
  always_comb begin
    if (sum > 29'sd8388607)
      sat = 24'sh7fffff;
    else if (sum < -29'sd8388608)
      sat = 24'sh800000;
    else
      sat = sum[COORD_W-1:0];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kv    <= 1'b0;
      cv    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            t_reg      <= in_t;
            res_span   <= '0;
            res_point  <= '0;
            res_status <= ST_WRITE;
            state      <= S_DONE;
            if (in_op == OP_EVAL) begin
              res_status <= ST_OOD;
              if (point_count > CNT_W'(degree)) begin
                kcnt  <= CNT_W'(degree);
                kv    <= 1'b0;
                found <= 1'b0;
                state <= S_SEARCH;
              end
            end
          end
        end
        S_SEARCH: begin
          // Issue one knot read a cycle and check the span on the last one
          kcnt <= kcnt + CNT_W'(1);
          kidx <= kcnt;
          kv   <= (kcnt <= point_count);
          if (kv) begin
            prev <= knot_qa;
            if (kidx == CNT_W'(degree)) begin
              knot_p <= knot_qa;
            end else if (hit && !found) begin
              found <= 1'b1;
              span  <= kidx - IDX_W'(1);
            end
          end
          if (at_end) begin
            kv <= 1'b0;
            if (t_reg < knot_p || t_reg > knot_qa) begin
              state <= S_DONE;
            end else if (t_reg == knot_qa) begin
              span  <= point_count - IDX_W'(1);
              ccnt  <= '0;
              state <= S_COPY;
            end else if (found || hit) begin
              if (!found)
                span <= kidx - IDX_W'(1);
              ccnt  <= '0;
              state <= S_COPY;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_COPY: begin
          ccnt <= ccnt + 4'd1;
          cidx <= ccnt[WADDR_W-1:0];
          cv   <= (ccnt <= 4'(degree));
          if (cv && cidx == degree) begin
            cv    <= 1'b0;
            jj    <= WADDR_W'(1);
            kk    <= degree;
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_LD;
        end
        S_LD: begin
          coord <= '0;
          if (knot_qb <= knot_qa || t_reg <= knot_qa) begin
            alpha <= '0;
            state <= S_MUL;
          end else if (w_num >= w_den) begin
            alpha <= KNOT_W'(1 << FRAC_BITS);
            state <= S_MUL;
          end else begin
            rem   <= w_num;
            den   <= w_den;
            dcnt  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // One quotient bit a cycle; the last bit goes straight into alpha
          if (rem2 >= {1'b0, den}) begin
            rem <= KNOT_W'(rem2 - {1'b0, den});
            quo <= {quo[FRAC_BITS-2:0], 1'b1};
          end else begin
            rem <= rem2[KNOT_W-1:0];
            quo <= {quo[FRAC_BITS-2:0], 1'b0};
          end
          dcnt <= dcnt + 4'd1;
          if (dcnt == 4'd15) begin
            alpha <= {1'b0, quo[FRAC_BITS-2:0], (rem2 >= {1'b0, den})};
            state <= S_MUL;
          end
        end
        S_MUL: begin
          ph    <= 26'(mag_hi_unused * alpha);
          pl    <= 33'(mag[FRAC_BITS-1:0] * alpha);
          neg   <= diff[COORD_W];
          a_reg <= ca;
          state <= S_ACC;
        end
        S_ACC: begin
          new_w[coord*COORD_W +: COORD_W] <= sat;
          coord <= coord + 2'd1;
          state <= (coord == 2'd2) ? S_WR : S_MUL;
        end
        S_WR: begin
          state <= S_RD;
          if (kk > jj) begin
            kk <= kk - WADDR_W'(1);
          end else if (jj < degree) begin
            jj <= jj + WADDR_W'(1);
            kk <= degree;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          // new_w still holds the last interpolated point
          res_point  <= new_w;
          res_span   <= span;
          res_status <= ST_POINT;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready)
            state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
      m_tuser  <= '0;
    end else if (state == S_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {1'b0, res_point, res_span};
      m_tuser  <= res_status;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Checks
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < den))
    else $error("divider remainder not below divisor");

  a_span_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_POINT) |->
      (m_tdata[6:0] >= IDX_W'(degree) && m_tdata[6:0] < point_count))
    else $error("span outside degree..n-1");

  a_zero_fill: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_POINT) |-> (m_tdata == '0))
    else $error("non-point result carries data");

  a_alpha_max: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC) |-> (alpha <= KNOT_W'(1 << FRAC_BITS)))
    else $error("weight above one");

endmodule
